### sv/assert_macros.svh
// Assertion macros shared by the gamepad event extractor modules.
// Each macro expects the module to have aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gpe_pkg.sv
// Types, codes and the stick classifier for the gamepad event extractor.
// No dependencies.
package gpe_pkg;

    localparam int BTN_W = 16;
    localparam int DZ_W  = 7;
    localparam logic [7:0] STICK_CENTRE = 8'h80;

    localparam logic [2:0] DIR_NEUTRAL = 3'd0;
    localparam logic [2:0] DIR_UP      = 3'd1;
    localparam logic [2:0] DIR_DOWN    = 3'd2;
    localparam logic [2:0] DIR_LEFT    = 3'd3;
    localparam logic [2:0] DIR_RIGHT   = 3'd4;

    localparam logic [2:0] EV_BTN_PRESS   = 3'd0;
    localparam logic [2:0] EV_BTN_RELEASE = 3'd1;
    localparam logic [2:0] EV_LEFT_STICK  = 3'd2;
    localparam logic [2:0] EV_RIGHT_STICK = 3'd3;
    localparam logic [2:0] EV_LT_PRESS    = 3'd4;
    localparam logic [2:0] EV_LT_RELEASE  = 3'd5;
    localparam logic [2:0] EV_RT_PRESS    = 3'd6;
    localparam logic [2:0] EV_RT_RELEASE  = 3'd7;

    // Pending events of one report, cleared one at a time by the back end.
    typedef struct packed {
        logic [BTN_W-1:0] btn_chg;
        logic [BTN_W-1:0] btn_now;
        logic             ls_vld;
        logic [1:0]       ls_dir;
        logic             rs_vld;
        logic [1:0]       rs_dir;
        logic             lt_vld;
        logic             lt_rel;
        logic             rt_vld;
        logic             rt_rel;
    } gpe_job_t;

    function automatic logic [2:0] classify(input logic [7:0] x, input logic [7:0] y,
                                            input logic [DZ_W-1:0] dz);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [2:0] cls;
        lo = STICK_CENTRE - {1'b0, dz};
        hi = STICK_CENTRE + {1'b0, dz};
        if (x < lo) begin
            cls = DIR_LEFT;
        end else if (x > hi) begin
            cls = DIR_RIGHT;
        end else if (y < lo) begin
            cls = DIR_UP;
        end else if (y > hi) begin
            cls = DIR_DOWN;
        end else begin
            cls = DIR_NEUTRAL;
        end
        return cls;
    endfunction

    function automatic logic job_any(input gpe_job_t j);
        return (|j.btn_chg) | j.ls_vld | j.rs_vld | j.lt_vld | j.rt_vld;
    endfunction

endpackage

### sv/gpe_front.sv
// Front end: takes reports, compares with held state, builds event jobs.
// Depends on gpe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gpe_front import gpe_pkg::*; #(
    parameter int NUM_BUTTONS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [DZ_W-1:0]  cfg_wr_data,
    input  logic             in_vld,
    output logic             in_rdy,
    input  logic [63:0]      in_data,
    output logic             job_push,
    output gpe_job_t         job,
    input  logic             q_full
);

    localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((32'd1 << NUM_BUTTONS) - 32'd1);

    logic [DZ_W-1:0]  deadzone_reg;
    logic [BTN_W-1:0] prev_btn_reg;
    logic [2:0]       ls_dir_reg;
    logic [2:0]       rs_dir_reg;
    logic             lt_held_reg;
    logic             rt_held_reg;

    logic [7:0]       lx, ly, rx, ry, lt, rt;
    logic [BTN_W-1:0] btns;
    logic [2:0]       ls_cls, rs_cls;
    logic             accept;

    assign lx   = in_data[7:0];
    assign ly   = in_data[15:8];
    assign rx   = in_data[23:16];
    assign ry   = in_data[31:24];
    assign btns = in_data[47:32];
    assign lt   = in_data[55:48];
    assign rt   = in_data[63:56];

    assign in_rdy = !q_full;
    assign accept = in_vld && in_rdy;

    assign ls_cls = classify(lx, ly, deadzone_reg);
    assign rs_cls = classify(rx, ry, deadzone_reg);

    always_comb begin
        job.btn_chg = (btns ^ prev_btn_reg) & BTN_MASK;
        job.btn_now = btns;
        job.ls_vld  = (ls_cls != DIR_NEUTRAL) && (ls_cls != ls_dir_reg);
        job.ls_dir  = 2'(ls_cls - 3'd1);
        job.rs_vld  = (rs_cls != DIR_NEUTRAL) && (rs_cls != rs_dir_reg);
        job.rs_dir  = 2'(rs_cls - 3'd1);
        job.lt_vld  = (lt != 8'd0) != lt_held_reg;
        job.lt_rel  = lt_held_reg;
        job.rt_vld  = (rt != 8'd0) != rt_held_reg;
        job.rt_rel  = rt_held_reg;
    end

    assign job_push = accept && job_any(job);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= DZ_W'(8);
            prev_btn_reg <= '0;
            ls_dir_reg   <= DIR_NEUTRAL;
            rs_dir_reg   <= DIR_NEUTRAL;
            lt_held_reg  <= 1'b0;
            rt_held_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                deadzone_reg <= cfg_wr_data;
            end
            if (accept) begin
                prev_btn_reg <= btns;
                ls_dir_reg   <= ls_cls;
                rs_dir_reg   <= rs_cls;
                lt_held_reg  <= lt != 8'd0;
                rt_held_reg  <= rt != 8'd0;
            end
        end
    end

    `GPE_ASSERT_NOW(a_push_has_events, job_push, job_any(job), "empty job pushed")

endmodule

### sv/gpe_queue.sv
// Two-entry job queue between front and back end.
// Depends on gpe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gpe_queue import gpe_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  gpe_job_t wr_job,
    output logic     full,
    input  logic     pop,
    output logic     rd_vld,
    output gpe_job_t rd_job
);

    localparam int DEPTH = 2;

    gpe_job_t mem [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full   = cnt_reg == 2'(DEPTH);
    assign rd_vld = cnt_reg != 2'd0;
    assign rd_job = mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    `GPE_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
    `GPE_ASSERT_NOW(a_no_underflow, pop, rd_vld, "pop from empty queue")

endmodule

### sv/gpe_back.sv
// Back end: drains one job at a time, one event per cycle while the receiver accepts, into the output register.
// Depends on gpe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gpe_back import gpe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_vld,
    input  gpe_job_t   q_job,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [2:0] m_tuser,
    output logic       m_tlast
);

    gpe_job_t   cur_reg;
    logic       busy_reg;
    logic       m_tvalid_reg;
    logic [2:0] kind_reg;
    logic [3:0] num_reg;
    logic [1:0] dir_reg;
    logic       last_reg;

    gpe_job_t   rem;
    logic [3:0] idx;
    logic [2:0] ev_kind;
    logic [3:0] ev_num;
    logic [1:0] ev_dir;
    logic       out_free;
    logic       emit;
    logic       done;

    always_comb begin
        idx = '0;
        for (int i = BTN_W - 1; i >= 0; i--) begin
            if (cur_reg.btn_chg[i]) begin
                idx = 4'(i);
            end
        end
    end

    always_comb begin
        rem     = cur_reg;
        ev_kind = EV_RT_PRESS;
        ev_num  = '0;
        ev_dir  = '0;
        if (|cur_reg.btn_chg) begin
            ev_kind     = cur_reg.btn_now[idx] ? EV_BTN_PRESS : EV_BTN_RELEASE;
            ev_num      = idx;
            rem.btn_chg = cur_reg.btn_chg & (cur_reg.btn_chg - BTN_W'(1));
        end else if (cur_reg.ls_vld) begin
            ev_kind    = EV_LEFT_STICK;
            ev_dir     = cur_reg.ls_dir;
            rem.ls_vld = 1'b0;
        end else if (cur_reg.rs_vld) begin
            ev_kind    = EV_RIGHT_STICK;
            ev_dir     = cur_reg.rs_dir;
            rem.rs_vld = 1'b0;
        end else if (cur_reg.lt_vld) begin
            ev_kind    = cur_reg.lt_rel ? EV_LT_RELEASE : EV_LT_PRESS;
            rem.lt_vld = 1'b0;
        end else begin
            ev_kind    = cur_reg.rt_rel ? EV_RT_RELEASE : EV_RT_PRESS;
            rem.rt_vld = 1'b0;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign done     = emit && !job_any(rem);
    assign q_pop    = q_vld && (!busy_reg || done);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_job;
        end else if (emit) begin
            cur_reg <= rem;
        end
        if (emit) begin
            kind_reg <= ev_kind;
            num_reg  <= ev_num;
            dir_reg  <= ev_dir;
            last_reg <= !job_any(rem);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, dir_reg, num_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    `GPE_ASSERT_NOW(a_rise_needs_job, $rose(m_tvalid_reg), $past(busy_reg), "item without job")
    `GPE_ASSERT_NEXT(a_done_frees, done && !q_pop, !busy_reg, "busy after last event")

endmodule

### sv/gamepad_report_event_extractor_core.sv
// Gamepad report event extractor, top level.
// Depends on gpe_pkg, gpe_front, gpe_queue, gpe_back and assert_macros.svh.
//
// Usage:
//   s_* : one gamepad report per item. Every report is compared with the
//         state left by earlier ones; reports that change nothing give no item.
//   m_* : change events in order: buttons (ascending), left stick, right
//         stick, left trigger, right trigger. tlast marks a report's final event.
//   cfg_wr_en / cfg_wr_data : stick deadzone, write while idle.
// Path: an accepted report goes into the job queue, then into the back
//   end's job register; each event is registered at the output.
// Throughput: one event per cycle from the back end while the receiver
//   accepts; a report gives at most 20 events. A report is accepted
//   every cycle while the two-entry job queue has room.
// Reset clears held buttons, stick directions and trigger states and sets
//   the deadzone to 8. A stalled receiver holds the output item; the queue
//   then fills and s_tready drops.
module gamepad_report_event_extractor_core import gpe_pkg::*; #(
    parameter int NUM_BUTTONS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [DZ_W-1:0] cfg_wr_data,
    input  logic            s_tvalid,
    output logic            s_tready,
    // left_x, left_y, right_x, right_y, buttons[15:0], left_trigger, right_trigger
    input  logic [63:0]     s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // button_number[3:0], direction[5:4], zero padding
    output logic [7:0]      m_tdata,
    // event_kind
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    gpe_job_t push_job;
    gpe_job_t pop_job;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_vld;

    gpe_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_vld     (s_tvalid),
        .in_rdy     (s_tready),
        .in_data    (s_tdata),
        .job_push   (push),
        .job        (push_job),
        .q_full     (q_full)
    );

    gpe_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wr_job (push_job),
        .full   (q_full),
        .pop    (pop),
        .rd_vld (q_vld),
        .rd_job (pop_job)
    );

    gpe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_vld   (q_vld),
        .q_job   (pop_job),
        .q_pop   (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
